### hw/rtl/pwm_incremental_pid_duty_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef PWM_INCREMENTAL_PID_DUTY_MACROS_SVH
`define PWM_INCREMENTAL_PID_DUTY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPID_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ppid_pkg.sv
package ppid_pkg;

    localparam int LEVEL_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 16;
    localparam int CAL_PROD_W = LEVEL_W + GAIN_W;
    localparam int ERR_W      = 26;
    localparam int D1_W       = 27;
    localparam int D2_W       = 28;
    localparam int MA_W       = 28;
    localparam int MB_W       = 17;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = 47;
    localparam int Q_W        = ACC_W - 12;
    localparam int STEP_W     = 12;
    localparam int NEWD_W     = 21;
    localparam int SUM_W      = 26;
    localparam int OSC_W      = 5;
    localparam int PH_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;

    localparam int STARTUP_STEPS_DEF = 30;
    localparam int DUTY_MAX          = 4500;

    localparam logic [GAIN_W-1:0] CAL_RST = 16'd256;
    localparam logic [GAIN_W-1:0] KP_RST  = 16'd819;
    localparam logic [GAIN_W-1:0] KI_RST  = 16'd819;
    localparam logic [GAIN_W-1:0] KD_RST  = 16'd0;

    localparam logic signed [ERR_W-1:0]  SMALL_ERR_MAX = 26'sd51;
    localparam logic signed [ERR_W-1:0]  DEADBAND      = 26'sd256;
    localparam logic signed [ERR_W-1:0]  BIG_ERR       = 26'sd768;
    localparam logic signed [STEP_W-1:0] STEP_WIDE     = 12'sd1280;
    localparam logic signed [STEP_W-1:0] STEP_NARROW   = 12'sd768;
    localparam logic signed [ACC_W-1:0]  OSC_LIMIT     = 47'sd20971520;
    localparam logic [OSC_W-1:0]         OSC_TRIP      = 5'd20;
    localparam logic [PH_W-1:0]          PHASE_TRIP    = 9'd500;
    localparam logic [LEVEL_W-1:0]       LEVEL_MAX     = 24'hFFFFFF;

    localparam logic signed [SUM_W-1:0] DUTY_HI  = SUM_W'(DUTY_MAX * 256);
    localparam logic signed [SUM_W-1:0] DUTY_CAP = SUM_W'((DUTY_MAX - 1) * 256);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CAL = 3'd0;
    localparam t_cfg_idx CFG_KP  = 3'd1;
    localparam t_cfg_idx CFG_KI  = 3'd2;
    localparam t_cfg_idx CFG_KD  = 3'd3;
    localparam t_cfg_idx CFG_AOE = 3'd4;

    typedef logic [1:0] t_mul_sel;
    localparam t_mul_sel MUL_CAL = 2'd0;
    localparam t_mul_sel MUL_P   = 2'd1;
    localparam t_mul_sel MUL_I   = 2'd2;
    localparam t_mul_sel MUL_D   = 2'd3;

    typedef struct packed {
        logic     ld_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_meas;
        logic     ld_err;
        logic     ld_diff;
        logic     acc_clr;
        logic     acc_add;
        logic     ld_step;
        logic     ld_out;
    } t_cmd;

endpackage

### hw/rtl/ppid_ctrl.sv
`include "pwm_incremental_pid_duty_macros.svh"

module ppid_ctrl import ppid_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CAL  = 4'd1;
    localparam logic [3:0] ST_MEAS = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_DIFF = 4'd4;
    localparam logic [3:0] ST_MP   = 4'd5;
    localparam logic [3:0] ST_MI   = 4'd6;
    localparam logic [3:0] ST_MD   = 4'd7;
    localparam logic [3:0] ST_MACC = 4'd8;
    localparam logic [3:0] ST_STEP = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = ST_CAL;
                end
            end
            ST_CAL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CAL;
                n_state       = ST_MEAS;
            end
            ST_MEAS: begin
                o_cmd.ld_meas = 1'b1;
                n_state       = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.ld_err = 1'b1;
                n_state      = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.ld_diff = 1'b1;
                n_state       = ST_MP;
            end
            ST_MP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state       = ST_MI;
            end
            ST_MI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_I;
                o_cmd.acc_clr = 1'b1;
                n_state       = ST_MD;
            end
            ST_MD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
                o_cmd.acc_add = 1'b1;
                n_state       = ST_MACC;
            end
            ST_MACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_STEP;
            end
            ST_STEP: begin
                o_cmd.ld_step = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PPID_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == ST_CAL, "accepted item did not start")
    `PPID_ASSERT_NEXT(a_out_stall_holds, (r_state == ST_OUT) && r_out_valid && !i_out_ready, (r_state == ST_OUT) && r_out_valid, "result overwritten while stalled")

endmodule

### hw/rtl/ppid_dp.sv
`include "pwm_incremental_pid_duty_macros.svh"

module ppid_dp import ppid_pkg::*; #(
    parameter int STARTUP_STEPS = STARTUP_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [LEVEL_W-1:0]       i_target_level,
    input  logic [LEVEL_W-1:0]       i_sensor_reading,
    input  logic [DUTY_W-1:0]        i_duty_now,
    output logic [NEWD_W-1:0]        o_new_duty,
    output logic signed [STEP_W-1:0] o_duty_step,
    output logic [LEVEL_W-1:0]       o_measured_level,
    output logic                     o_runaway,
    output logic                     o_late_phase
);

    localparam int AW = $clog2(STARTUP_STEPS + 1);
    localparam logic [AW-1:0] ACT_LIM = AW'(STARTUP_STEPS);

    logic [GAIN_W-1:0] r_cal, r_kp, r_ki, r_kd;
    logic              r_aoe;

    logic [LEVEL_W-1:0] r_target, r_reading;
    logic [DUTY_W-1:0]  r_duty;

    logic signed [PROD_W-1:0] r_prod;
    logic [LEVEL_W-1:0]       r_meas;
    logic signed [ERR_W-1:0]  r_err, r_e;
    logic                     r_big;
    logic signed [D1_W-1:0]   r_d1;
    logic signed [D2_W-1:0]   r_d2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [STEP_W-1:0] r_step;

    logic signed [ERR_W-1:0] r_prev, r_pprev;
    logic [AW-1:0]           r_act;
    logic [OSC_W-1:0]        r_osc;
    logic [PH_W-1:0]         r_phase;
    logic                    r_late, r_runaway;

    logic [NEWD_W-1:0]        r_out_new;
    logic signed [STEP_W-1:0] r_out_step;
    logic [LEVEL_W-1:0]       r_out_meas;
    logic                     r_out_run, r_out_late;

    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic [LEVEL_W-1:0]       w_meas;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [ACC_W-1:0]  w_acc_rnd;
    logic signed [Q_W-1:0]    w_q;
    logic [AW-1:0]            w_act_nx;
    logic                     w_wide;
    logic signed [STEP_W-1:0] w_lim, w_nlim, w_step;
    logic                     w_osc_hit;
    logic [OSC_W-1:0]         w_osc_nx;
    logic [PH_W-1:0]          w_phase_nx;
    logic signed [SUM_W-1:0]  w_sum;
    logic [NEWD_W-1:0]        w_new;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_CAL: begin
                w_mul_a = $signed({{(MA_W-LEVEL_W){1'b0}}, r_reading});
                w_mul_b = $signed({1'b0, r_cal});
            end
            MUL_P: begin
                w_mul_a = MA_W'(r_d1);
                w_mul_b = $signed({1'b0, r_kp});
            end
            MUL_I: begin
                w_mul_a = MA_W'(r_e);
                w_mul_b = $signed({1'b0, r_ki});
            end
            MUL_D: begin
                w_mul_a = r_d2;
                w_mul_b = $signed({1'b0, r_kd});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_meas = (|r_prod[CAL_PROD_W-1:LEVEL_W+8]) ? LEVEL_MAX : r_prod[LEVEL_W+7:8];
    assign w_err  = $signed({2'b00, r_target}) - $signed({2'b00, r_meas});

    // truncate toward zero
    assign w_acc_rnd = r_acc + $signed({{(ACC_W-12){1'b0}}, {12{r_acc[ACC_W-1]}}});
    assign w_q       = w_acc_rnd[ACC_W-1:12];

    assign w_act_nx = (r_act < ACT_LIM) ? r_act + 1'b1 : r_act;
    assign w_wide   = (w_act_nx < ACT_LIM) && (r_err > BIG_ERR);
    assign w_lim    = w_wide ? STEP_WIDE : STEP_NARROW;
    assign w_nlim   = -w_lim;

    always_comb begin
        if (!r_big) begin
            w_step = '0;
        end else if (w_q > w_lim) begin
            w_step = w_lim;
        end else if (w_q < w_nlim) begin
            w_step = w_nlim;
        end else begin
            w_step = w_q[STEP_W-1:0];
        end
    end

    assign w_osc_hit  = (r_acc > OSC_LIMIT) || (r_acc < -OSC_LIMIT);
    assign w_osc_nx   = r_osc + OSC_W'(w_osc_hit);
    assign w_phase_nx = r_late ? r_phase : r_phase + 1'b1;

    assign w_sum = $signed({{(SUM_W-DUTY_W-8){1'b0}}, r_duty, 8'b0}) + SUM_W'(r_step);

    always_comb begin
        if (w_sum[SUM_W-1]) begin
            w_new = '0;
        end else if (w_sum > DUTY_HI) begin
            w_new = DUTY_CAP[NEWD_W-1:0];
        end else begin
            w_new = w_sum[NEWD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_target  <= i_target_level;
            r_reading <= i_sensor_reading;
            r_duty    <= i_duty_now;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.ld_meas) begin
            r_meas <= w_meas;
        end
        if (i_cmd.ld_err) begin
            r_err <= w_err;
            r_big <= (w_err > SMALL_ERR_MAX) || (w_err < -SMALL_ERR_MAX);
            r_e   <= ((w_err > -DEADBAND) && (w_err < DEADBAND)) ? '0 : w_err;
        end
        if (i_cmd.ld_diff) begin
            r_d1 <= D1_W'(r_e) - D1_W'(r_prev);
            r_d2 <= D2_W'(r_e) - (D2_W'(r_prev) <<< 1) + D2_W'(r_pprev);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.ld_step) begin
            r_step <= w_step;
        end
        if (i_cmd.ld_out) begin
            r_out_new  <= w_new;
            r_out_step <= r_step;
            r_out_meas <= r_meas;
            r_out_run  <= r_runaway;
            r_out_late <= r_late;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= CAL_RST;
            r_kp      <= KP_RST;
            r_ki      <= KI_RST;
            r_kd      <= KD_RST;
            r_aoe     <= 1'b0;
            r_prev    <= '0;
            r_pprev   <= '0;
            r_act     <= '0;
            r_osc     <= '0;
            r_phase   <= '0;
            r_late    <= 1'b0;
            r_runaway <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAL: r_cal <= i_cfg_data;
                    CFG_KP:  r_kp  <= i_cfg_data;
                    CFG_KI:  r_ki  <= i_cfg_data;
                    CFG_KD:  r_kd  <= i_cfg_data;
                    CFG_AOE: r_aoe <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.ld_step && r_big) begin
                r_pprev <= r_prev;
                r_prev  <= r_e;
                r_act   <= w_act_nx;
                if (r_aoe) begin
                    if (w_osc_nx >= OSC_TRIP) begin
                        r_osc     <= '0;
                        r_runaway <= 1'b1;
                    end else begin
                        r_osc <= w_osc_nx;
                    end
                    if (w_phase_nx >= PHASE_TRIP) begin
                        r_phase <= '0;
                        r_late  <= 1'b1;
                    end else begin
                        r_phase <= w_phase_nx;
                    end
                end
            end
        end
    end

    assign o_new_duty       = r_out_new;
    assign o_duty_step      = r_out_step;
    assign o_measured_level = r_out_meas;
    assign o_runaway        = r_out_run;
    assign o_late_phase     = r_out_late;

    `PPID_ASSERT_NEXT(a_runaway_sticky, r_runaway, r_runaway, "runaway flag cleared")
    `PPID_ASSERT_NEXT(a_step_range, i_cmd.ld_step, (r_step <= STEP_WIDE) && (r_step >= -STEP_WIDE), "step out of range")
    `PPID_ASSERT_NEXT(a_small_err_zero, i_cmd.ld_step && !r_big, r_step == '0, "nonzero step on small error")
    `PPID_ASSERT_IMPL(a_phase_bound, 1'b1, r_phase < PHASE_TRIP, "phase count past trip")

endmodule

### hw/rtl/pwm_incremental_pid_duty.sv
// One shared 28x17 multiplier runs the calibration product and then the three
// gain products in turn, the gain products one per cycle. A new item is accepted
// only once the previous result has been loaded into the output register.
// A stalled output holds the controller in its last step until taken.
// Reset (i_rst_n low, synchronous) clears PID history, counters, flags,
// and loads the gain registers with their defaults.
module pwm_incremental_pid_duty import ppid_pkg::*; #(
    parameter int STARTUP_STEPS = STARTUP_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // target_level[23:0], sensor_reading[47:24], duty_now[63:48]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_duty[20:0], duty_step[32:21], measured_level[56:33],
    // runaway[57], late_phase[58], zero[63:59]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd                     w_cmd;
    logic [NEWD_W-1:0]        w_new_duty;
    logic signed [STEP_W-1:0] w_duty_step;
    logic [LEVEL_W-1:0]       w_meas;
    logic                     w_runaway, w_late;

    ppid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    ppid_dp #(
        .STARTUP_STEPS (STARTUP_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_target_level   (s_axis_tdata[23:0]),
        .i_sensor_reading (s_axis_tdata[47:24]),
        .i_duty_now       (s_axis_tdata[63:48]),
        .o_new_duty       (w_new_duty),
        .o_duty_step      (w_duty_step),
        .o_measured_level (w_meas),
        .o_runaway        (w_runaway),
        .o_late_phase     (w_late)
    );

    assign m_axis_tdata = {5'b0, w_late, w_runaway, w_meas, w_duty_step, w_new_duty};

endmodule

### tb/tb_pwm_incremental_pid_duty.sv
`timescale 1ns / 1ps

module tb_pwm_incremental_pid_duty;

    // Predictor constants; step limits in Q.8 duty units, errors in level units
    localparam longint SMALL_ERR       = 51;
    localparam longint DEAD_ZONE       = 256;
    localparam longint WIDE_ERR        = 768;
    localparam longint STEP_LIM_WIDE   = 1280;
    localparam longint STEP_LIM_NARROW = 768;
    localparam longint OSC_ACC_LIM     = 64'd20 << 20;
    localparam int     OSC_TRIPS       = 20;
    localparam int     PHASE_TRIPS     = 500;
    localparam int     STARTUP         = 30;
    localparam int     DUTY_TOP        = 4500;
    localparam longint LEVEL_TOP       = 24'hFFFFFF;

    localparam int DRAIN_PAD   = 16;
    localparam int END_PAD     = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int N_DIR       = 22;

    // matches s_axis_tdata bit for bit
    typedef struct packed {
        logic [15:0] duty;
        logic [23:0] reading;
        logic [23:0] target;
    } t_pid_item;

    // matches m_axis_tdata bit for bit
    typedef struct packed {
        logic [4:0]  pad;
        logic        late;
        logic        runaway;
        logic [23:0] level;
        logic [11:0] step;
        logic [20:0] duty;
    } t_duty_result;

    typedef struct packed {
        t_pid_item    item;
        logic         typed;
        t_duty_result want;
    } t_stim_row;

    // item: {duty, reading, target}; want: {pad, late, runaway, level, step, duty}
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        '{'{16'd0, 24'd0, 24'd0}, 1'b1, '{5'd0, 1'b0, 1'b0, 24'd0, 12'd0, 21'd0}},
        '{'{16'hFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
          '{5'd0, 1'b0, 1'b0, 24'hFFFFFF, 12'd0, 21'd1151744}},
        '{'{16'd4500, 24'd49, 24'd100}, 1'b1,
          '{5'd0, 1'b0, 1'b0, 24'd49, 12'd0, 21'd1152000}},
        '{'{16'd4501, 24'd100, 24'd49}, 1'b1,
          '{5'd0, 1'b0, 1'b0, 24'd100, 12'd0, 21'd1151744}},
        '{'{16'd1000, 24'd100, 24'd152}, 1'b0, '0},
        '{'{16'd1000, 24'd356, 24'd100}, 1'b0, '0},
        '{'{16'd1000, 24'd100, 24'd355}, 1'b0, '0},
        '{'{16'd0, 24'd0, 24'hFFFFFF}, 1'b0, '0},
        '{'{16'd0, 24'hFFFFFF, 24'd0}, 1'b0, '0},
        '{'{16'd4500, 24'd0, 24'hFFFFFF}, 1'b0, '0},
        '{'{16'hFFFF, 24'hFFFFFF, 24'd0}, 1'b0, '0},
        '{'{16'd2000, 24'd100, 24'd868}, 1'b0, '0},
        '{'{16'd2000, 24'd100, 24'd869}, 1'b0, '0},
        '{'{16'hAAAA, 24'h555555, 24'hAAAAAA}, 1'b0, '0},
        '{'{16'h5555, 24'hAAAAAA, 24'h555555}, 1'b0, '0},
        '{'{16'd3000, 24'd0, 24'd20000}, 1'b0, '0},
        '{'{16'd3000, 24'd20000, 24'd0}, 1'b0, '0},
        '{'{16'd2500, 24'd5051, 24'd5000}, 1'b1,
          '{5'd0, 1'b0, 1'b0, 24'd5051, 12'd0, 21'd640000}},
        '{'{16'd1, 24'd0, 24'd300000}, 1'b0, '0},
        '{'{16'd4499, 24'd300000, 24'd0}, 1'b0, '0},
        '{'{16'd10, 24'd0, 24'd256}, 1'b0, '0},
        '{'{16'hFFFF, 24'd0, 24'd0}, 1'b1,
          '{5'd0, 1'b0, 1'b0, 24'd0, 12'd0, 21'd1151744}}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [ppid_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [ppid_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               i_cfg_we;
    logic [ppid_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [ppid_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    // predictor copy of registers and loop state
    longint cal_g, kp_g, ki_g, kd_g;
    bit     osc_guard;
    longint err_d1, err_d2;
    int     pid_steps, osc_cnt, phase_cnt;
    bit     late_q, runaway_q;

    t_duty_result pending_duty_q [$];
    t_duty_result got_r, want_r;
    int           mismatches = 0;
    int           stall_cnt = 0;
    bit           no_idle = 1'b0;
    bit           hold_sink = 1'b0;

    pwm_incremental_pid_duty DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint calibrate(logic [23:0] reading);
        longint p;
        p = longint'(reading);
        p = (p * cal_g) >> 8;
        return (p > LEVEL_TOP) ? LEVEL_TOP : p;
    endfunction

    function automatic t_duty_result next_duty(t_pid_item it);
        longint tgt, lvl, err, e, acc, stp, lim, sum;
        t_duty_result r;
        lvl = calibrate(it.reading);
        tgt = longint'(it.target);
        err = tgt - lvl;
        stp = 0;
        if (err > SMALL_ERR || err < -SMALL_ERR) begin
            e = (err > -DEAD_ZONE && err < DEAD_ZONE) ? 0 : err;
            acc = kp_g * (e - err_d1) + ki_g * e + kd_g * (e - 2 * err_d1 + err_d2);
            err_d2 = err_d1;
            err_d1 = e;
            if (pid_steps < STARTUP) pid_steps++;
            stp = acc / 4096;
            lim = (pid_steps < STARTUP && err > WIDE_ERR) ? STEP_LIM_WIDE : STEP_LIM_NARROW;
            if (stp > lim) stp = lim;
            else if (stp < -lim) stp = -lim;
            if (osc_guard) begin
                if (acc > OSC_ACC_LIM || acc < -OSC_ACC_LIM) osc_cnt++;
                if (osc_cnt >= OSC_TRIPS) begin
                    runaway_q = 1'b1;
                    osc_cnt = 0;
                end
                if (!late_q) phase_cnt++;
                if (phase_cnt >= PHASE_TRIPS) begin
                    phase_cnt = 0;
                    late_q = 1'b1;
                end
            end
        end
        sum = longint'(it.duty);
        sum = sum * 256 + stp;
        if (sum < 0) sum = 0;
        else if (sum > DUTY_TOP * 256) sum = (DUTY_TOP - 1) * 256;
        r = '0;
        r.duty = sum[20:0];
        r.step = stp[11:0];
        r.level = lvl[23:0];
        r.runaway = runaway_q;
        r.late = late_q;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(t_pid_item it, logic typed, t_duty_result want);
        t_duty_result predicted;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = it;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = next_duty(it);
        pending_duty_q.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_duty_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic set_reg(ppid_pkg::t_cfg_idx idx, logic [15:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            ppid_pkg::CFG_CAL: cal_g = longint'(val);
            ppid_pkg::CFG_KP:  kp_g = longint'(val);
            ppid_pkg::CFG_KI:  ki_g = longint'(val);
            ppid_pkg::CFG_KD:  kd_g = longint'(val);
            ppid_pkg::CFG_AOE: osc_guard = val[0];
            default: ;
        endcase
    endtask

    // target mostly placed at a chosen error distance from the calibrated level, else random
    task automatic run_random(int n);
        t_pid_item it;
        longint lvl, mag, tgt;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: it.reading = 24'($urandom);
                1: it.reading = 24'($urandom_range(0, 'hFFFF));
                2: it.reading = 24'($urandom_range(0, 'hFFF));
                default: it.reading = 24'($urandom_range(0, 'hFFFFF));
            endcase
            lvl = calibrate(it.reading);
            case ($urandom_range(0, 7))
                1: mag = longint'($urandom_range(0, SMALL_ERR));
                2: begin
                    case ($urandom_range(0, 5))
                        0: mag = SMALL_ERR;
                        1: mag = SMALL_ERR + 1;
                        2: mag = DEAD_ZONE - 1;
                        3: mag = DEAD_ZONE;
                        4: mag = WIDE_ERR;
                        default: mag = WIDE_ERR + 1;
                    endcase
                end
                3: mag = longint'($urandom_range(SMALL_ERR + 1, DEAD_ZONE - 1));
                4, 5: mag = longint'($urandom_range(DEAD_ZONE, 20000));
                default: mag = longint'($urandom_range(20000, 4000000));
            endcase
            tgt = $urandom_range(0, 1) ? lvl - mag : lvl + mag;
            if (tgt < 0) tgt = 0;
            else if (tgt > LEVEL_TOP) tgt = LEVEL_TOP;
            it.target = ($urandom_range(0, 7) == 0) ? 24'($urandom) : tgt[23:0];
            case ($urandom_range(0, 7))
                0: it.duty = 16'($urandom_range(0, 5));
                1: it.duty = 16'($urandom_range(DUTY_TOP - 5, DUTY_TOP + 5));
                2: it.duty = 16'($urandom);
                default: it.duty = 16'($urandom_range(0, DUTY_TOP));
            endcase
            send_item(it, 1'b0, '0);
        end
    endtask

    // result sink: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_sink = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r = t_duty_result'(m_axis_tdata);
            if (pending_duty_q.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
            end else begin
                want_r = pending_duty_q.pop_front();
                if (got_r.duty !== want_r.duty)
                    report_mismatch("new_duty", got_r.duty, want_r.duty);
                if (got_r.step !== want_r.step)
                    report_mismatch("duty_step", $signed(got_r.step), $signed(want_r.step));
                if (got_r.level !== want_r.level)
                    report_mismatch("measured_level", got_r.level, want_r.level);
                if (got_r.runaway !== want_r.runaway)
                    report_mismatch("runaway", got_r.runaway, want_r.runaway);
                if (got_r.late !== want_r.late)
                    report_mismatch("late_phase", got_r.late, want_r.late);
                if (got_r.pad !== want_r.pad)
                    report_mismatch("tdata pad", got_r.pad, want_r.pad);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = ppid_pkg::CFG_CAL;
        i_cfg_data = '0;
        cal_g = 256;
        kp_g = 819;
        ki_g = 819;
        kd_g = 0;
        osc_guard = 1'b0;
        err_d1 = 0;
        err_d2 = 0;
        pid_steps = 0;
        osc_cnt = 0;
        phase_cnt = 0;
        late_q = 1'b0;
        runaway_q = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        run_random(100);

        set_reg(ppid_pkg::CFG_AOE, 16'd1);
        set_reg(ppid_pkg::CFG_KP, 16'($urandom_range(0, 4095)));
        set_reg(ppid_pkg::CFG_KI, 16'($urandom_range(0, 4095)));
        set_reg(ppid_pkg::CFG_KD, 16'($urandom_range(0, 4095)));
        hold_sink = 1'b1;
        run_random(250);

        set_reg(ppid_pkg::CFG_CAL, 16'h0000);
        set_reg(ppid_pkg::CFG_KP, 16'h0000);
        set_reg(ppid_pkg::CFG_KI, 16'h0000);
        set_reg(ppid_pkg::CFG_KD, 16'h0000);
        run_random(60);

        set_reg(ppid_pkg::CFG_CAL, 16'hFFFF);
        set_reg(ppid_pkg::CFG_KP, 16'hFFFF);
        set_reg(ppid_pkg::CFG_KI, 16'hFFFF);
        set_reg(ppid_pkg::CFG_KD, 16'hFFFF);
        run_random(100);

        // unmapped indexes must be ignored
        for (int k = int'(ppid_pkg::CFG_AOE) + 1; k < (1 << ppid_pkg::CFG_IDX_W); k++)
            set_reg(ppid_pkg::t_cfg_idx'(k), 16'($urandom));
        set_reg(ppid_pkg::CFG_AOE, 16'd0);
        set_reg(ppid_pkg::CFG_CAL, 16'($urandom_range(128, 512)));
        set_reg(ppid_pkg::CFG_KP, 16'($urandom));
        set_reg(ppid_pkg::CFG_KI, 16'($urandom_range(0, 8191)));
        set_reg(ppid_pkg::CFG_KD, 16'($urandom_range(0, 2047)));
        run_random(100);

        set_reg(ppid_pkg::CFG_AOE, 16'hFFFF);
        set_reg(ppid_pkg::CFG_CAL, 16'd256);
        set_reg(ppid_pkg::CFG_KP, 16'($urandom_range(0, 4095)));
        set_reg(ppid_pkg::CFG_KI, 16'($urandom_range(0, 4095)));
        run_random(160);
        drain();
        run_random(160);

        no_idle = 1'b1;
        run_random(120);

        drain();
        repeat (END_PAD) @(negedge i_clk);
        if (mismatches == 0 && pending_duty_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
